>>> src/assert_macros.svh
// Assertion helpers shared by the RTL in this folder.
// Each macro needs clk and arst_n visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> src/cbf_pkg.sv
// Shared constants and request codes for the complex beamforming MAC.
// No dependencies.
`timescale 1ns / 1ps

package cbf_pkg;

	localparam int ANTENNAS_DEF = 8;
	localparam int BEAMS_DEF    = 8;

	localparam int SLOT_W   = 6;
	localparam int SAMPLE_W = 16;
	localparam int MULT_W   = 2 * SAMPLE_W;
	localparam int PROD_W   = MULT_W + 1;
	localparam int ACC_W    = 48;
	localparam int BEAM_W   = 3;

	typedef enum logic {
		REQ_COEF   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_type_t;

endpackage

>>> src/complex_beamform_8x8_mac.sv
// Complex beamforming MAC: weight store, BEAMS parallel complex MACs and
// a result buffer that drains one beam per beat. Depends on cbf_pkg and
// assert_macros.svh.
//
// Request channel (req_valid / req_stall): a coefficient beat writes one
// complex weight at slot antenna*BEAMS+beam; a sample beat carries one
// complex sample and its antenna index. Out-of-range slots are dropped.
// Result channel (res_valid / res_stall): after the sample of the highest
// antenna, BEAMS beats follow, beams in ascending order, last on the final.
// Throughput: one request beat per cycle while req_stall is low. A vector
// of ANTENNAS samples yields BEAMS result beats, so the result buffer limits
// the sustained rate when BEAMS exceeds ANTENNAS.
// After the highest-antenna sample is accepted, its weight row is read with
// it into stage 1, stage 2 registers the products, then accumulate and buffer
// load present the first result beat.
// When res_stall holds and the buffer is still full, a highest-antenna
// sample waits in the multiply stage and req_stall is raised.
// Reset clears the pipeline valids and the result buffer; weights and
// accumulators are undefined until written.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module complex_beamform_8x8_mac
	import cbf_pkg::*;
#(
	parameter int ANTENNAS = ANTENNAS_DEF,
	parameter int BEAMS    = BEAMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       req_type,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [SAMPLE_W-1:0] value_re,
	input  logic signed [SAMPLE_W-1:0] value_im,

	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [BEAM_W-1:0]          beam,
	output logic signed [ACC_W-1:0]    acc_re,
	output logic signed [ACC_W-1:0]    acc_im,
	output logic                       last
);

	localparam int AW = $clog2(ANTENNAS);
	localparam int BW = $clog2(BEAMS);
	localparam int CW = $clog2(BEAMS + 1);
	localparam logic [AW-1:0] LAST_ANT = AW'(ANTENNAS - 1);
	localparam logic [BW-1:0] LAST_BEAM = BW'(BEAMS - 1);

	logic                 req_acc;
	logic                 res_acc;
	logic                 adv;
	logic                 buf_free;
	logic                 snap;
	logic                 sample_ok;
	logic                 wr_hit;
	logic                 wr_en;
	logic [AW-1:0]        wr_ant;
	logic [BW-1:0]        wr_beam;
	logic [AW-1:0]        rd_ant;

	// stage 1: sample and weight row
	logic                       v_s1;
	logic [AW-1:0]              ant_s1;
	logic signed [SAMPLE_W-1:0] xre_s1;
	logic signed [SAMPLE_W-1:0] xim_s1;
	logic signed [SAMPLE_W-1:0] wre_s1 [BEAMS];
	logic signed [SAMPLE_W-1:0] wim_s1 [BEAMS];

	// stage 2: complex products
	logic                       v_s2;
	logic [AW-1:0]              ant_s2;
	logic signed [PROD_W-1:0]   pre_s2 [BEAMS];
	logic signed [PROD_W-1:0]   pim_s2 [BEAMS];

	logic signed [MULT_W-1:0]   m_rr [BEAMS];
	logic signed [MULT_W-1:0]   m_ii [BEAMS];
	logic signed [MULT_W-1:0]   m_ri [BEAMS];
	logic signed [MULT_W-1:0]   m_ir [BEAMS];

	logic signed [ACC_W-1:0]    acc_re_q [BEAMS];
	logic signed [ACC_W-1:0]    acc_im_q [BEAMS];
	logic signed [ACC_W-1:0]    sum_re [BEAMS];
	logic signed [ACC_W-1:0]    sum_im [BEAMS];

	logic signed [ACC_W-1:0]    ob_re_q [BEAMS];
	logic signed [ACC_W-1:0]    ob_im_q [BEAMS];
	logic [CW-1:0]              cnt_q;
	logic [BW-1:0]              idx_q;

	assign req_acc   = req_valid && !req_stall;
	assign res_acc   = res_valid && !res_stall;
	assign buf_free  = (cnt_q == '0) || ((cnt_q == CW'(1)) && !res_stall);
	assign adv       = !(v_s2 && (ant_s2 == LAST_ANT) && !buf_free);
	assign req_stall = !adv;
	assign snap      = adv && v_s2 && (ant_s2 == LAST_ANT);

	assign sample_ok = (req_type == REQ_SAMPLE) && (int'(slot) < ANTENNAS);
	assign rd_ant    = slot[AW-1:0];

	// split a coefficient slot into antenna and beam
	always_comb begin
		wr_hit  = 1'b0;
		wr_ant  = '0;
		wr_beam = '0;
		for (int a = 0; a < ANTENNAS; a++) begin
			if (int'(slot) >= a * BEAMS && int'(slot) < (a + 1) * BEAMS) begin
				wr_hit  = 1'b1;
				wr_ant  = AW'(a);
				wr_beam = BW'(int'(slot) - a * BEAMS);
			end
		end
	end

	assign wr_en = req_acc && (req_type == REQ_COEF) && wr_hit;

	// one weight bank per beam, addressed by antenna
	for (genvar b = 0; b < BEAMS; b++) begin : g_bank
		logic [MULT_W-1:0] wmem_q [ANTENNAS];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_beam == BW'(b))) begin
				wmem_q[wr_ant] <= {value_re, value_im};
			end
			if (req_acc) begin
				wre_s1[b] <= wmem_q[rd_ant][MULT_W-1:SAMPLE_W];
				wim_s1[b] <= wmem_q[rd_ant][SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_acc && sample_ok;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			ant_s1 <= rd_ant;
			xre_s1 <= value_re;
			xim_s1 <= value_im;
		end
	end

	always_comb begin
		for (int b = 0; b < BEAMS; b++) begin
			m_rr[b] = xre_s1 * wre_s1[b];
			m_ii[b] = xim_s1 * wim_s1[b];
			m_ri[b] = xre_s1 * wim_s1[b];
			m_ir[b] = xim_s1 * wre_s1[b];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ant_s2 <= ant_s1;
			for (int b = 0; b < BEAMS; b++) begin
				pre_s2[b] <= {m_rr[b][MULT_W-1], m_rr[b]} - {m_ii[b][MULT_W-1], m_ii[b]};
				pim_s2[b] <= {m_ri[b][MULT_W-1], m_ri[b]} + {m_ir[b][MULT_W-1], m_ir[b]};
			end
		end
	end

	// antenna 0 starts a new sum
	always_comb begin
		for (int b = 0; b < BEAMS; b++) begin
			sum_re[b] = ((ant_s2 == '0) ? '0 : acc_re_q[b])
				+ {{(ACC_W - PROD_W){pre_s2[b][PROD_W-1]}}, pre_s2[b]};
			sum_im[b] = ((ant_s2 == '0) ? '0 : acc_im_q[b])
				+ {{(ACC_W - PROD_W){pim_s2[b][PROD_W-1]}}, pim_s2[b]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			for (int b = 0; b < BEAMS; b++) begin
				acc_re_q[b] <= sum_re[b];
				acc_im_q[b] <= sum_im[b];
			end
		end
	end

	// result buffer: load the whole vector, shift one beam out per beat
	always_ff @(posedge clk) begin
		if (snap) begin
			for (int b = 0; b < BEAMS; b++) begin
				ob_re_q[b] <= sum_re[b];
				ob_im_q[b] <= sum_im[b];
			end
		end else if (res_acc) begin
			for (int b = 0; b < BEAMS - 1; b++) begin
				ob_re_q[b] <= ob_re_q[b + 1];
				ob_im_q[b] <= ob_im_q[b + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (snap) begin
			cnt_q <= CW'(BEAMS);
			idx_q <= '0;
		end else if (res_acc) begin
			cnt_q <= cnt_q - CW'(1);
			idx_q <= idx_q + BW'(1);
		end
	end

	assign res_valid = (cnt_q != '0);
	assign beam      = BEAM_W'(idx_q);
	assign acc_re    = ob_re_q[0];
	assign acc_im    = ob_im_q[0];
	assign last      = (cnt_q == CW'(1));

	`ASSERT_ALWAYS(a_last_beam, !(res_valid && last) || (idx_q == LAST_BEAM), "last beat not on highest beam")
	`ASSERT_NEXT(a_vector_restart, res_acc && last, !res_valid || (idx_q == '0), "new vector does not start at beam 0")
	`ASSERT_ALWAYS(a_stall_cause, !req_stall || (v_s2 && (ant_s2 == LAST_ANT) && res_valid), "request stalled without pending vector")
	`ASSERT_NEXT(a_hold_s2, req_stall, v_s2 && $stable(ant_s2), "multiply stage moved while stalled")

endmodule
